// File: sv/eprp_pkg.sv
// ----------------------------------------------------------------------------
// eprp_pkg
// Shared constants and helpers for the point rotation pipeline.
// ----------------------------------------------------------------------------
package eprp_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int Q_WIDTH      = 34;
    localparam logic signed [Q_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Q_WIDTH-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [63:0]        HALF_Q30    = 64'sd536870912;

    function automatic logic signed [33:0] atan_unit(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // floor((a*b + 2^29) / 2^30) on Q30 values
    function automatic logic signed [Q_WIDTH-1:0] mul_q30(
        input logic signed [Q_WIDTH-1:0] a,
        input logic signed [Q_WIDTH-1:0] b
    );
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'(HALF_Q30);
        return Q_WIDTH'(p >>> 30);
    endfunction

endpackage

// File: sv/eprp_cordic.sv
// ----------------------------------------------------------------------------
// eprp_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of three half angles,
// one micro-rotation per stage, stall by a shared enable.
// ----------------------------------------------------------------------------
module eprp_cordic
    import eprp_pkg::*;
#(
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [2:0][ANGLE_WIDTH-1:0]   i_angle,
    output logic [2:0][Q_WIDTH-1:0]       o_cos,
    output logic [2:0][Q_WIDTH-1:0]       o_sin
);
    localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    logic signed [Q_WIDTH-1:0] z0 [3];
    logic signed [Q_WIDTH-1:0] r_x [NS][3];
    logic signed [Q_WIDTH-1:0] r_y [NS][3];
    logic signed [Q_WIDTH-1:0] r_z [NS][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            z0[a] = Q_WIDTH'($signed(i_angle[a])) <<< (31 - ANGLE_WIDTH);
        end
    end

    // step 0 starts from x = gain, y = 0
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                if (!z0[a][Q_WIDTH-1]) begin
                    r_x[0][a] <= CORDIC_GAIN;
                    r_y[0][a] <= CORDIC_GAIN;
                    r_z[0][a] <= z0[a] - atan_unit(0);
                end else begin
                    r_x[0][a] <= CORDIC_GAIN;
                    r_y[0][a] <= -CORDIC_GAIN;
                    r_z[0][a] <= z0[a] + atan_unit(0);
                end
                for (int s = 1; s < NS; s++) begin
                    if (!r_z[s-1][a][Q_WIDTH-1]) begin
                        r_x[s][a] <= r_x[s-1][a] - (r_y[s-1][a] >>> s);
                        r_y[s][a] <= r_y[s-1][a] + (r_x[s-1][a] >>> s);
                        r_z[s][a] <= r_z[s-1][a] - atan_unit(s);
                    end else begin
                        r_x[s][a] <= r_x[s-1][a] + (r_y[s-1][a] >>> s);
                        r_y[s][a] <= r_y[s-1][a] - (r_x[s-1][a] >>> s);
                        r_z[s][a] <= r_z[s-1][a] + atan_unit(s);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            o_cos[a] = r_x[NS-1][a];
            o_sin[a] = r_y[NS-1][a];
        end
    end
endmodule

// File: sv/eprp_quat.sv
// ----------------------------------------------------------------------------
// eprp_quat
// Quaternion from half-angle sines and cosines, then the rotation matrix.
// Four register stages, at most one multiplier level each.
// ----------------------------------------------------------------------------
module eprp_quat
    import eprp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2:0][Q_WIDTH-1:0]  i_cos,
    input  logic [2:0][Q_WIDTH-1:0]  i_sin,
    output logic [8:0][Q_WIDTH+2:0]  o_mat
);
    logic signed [Q_WIDTH-1:0] cr, sr, cp, sp, cw, sw;
    logic signed [Q_WIDTH-1:0] r_cwcp, r_swsp, r_cwsp, r_swcp;
    logic signed [Q_WIDTH-1:0] r_cr, r_sr;
    logic signed [Q_WIDTH-1:0] r_qw, r_qx, r_qy, r_qz;
    logic signed [Q_WIDTH-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [Q_WIDTH+2:0] r_m [9];

    assign cr = $signed(i_cos[0]);
    assign sr = $signed(i_sin[0]);
    assign cp = $signed(i_cos[1]);
    assign sp = $signed(i_sin[1]);
    assign cw = $signed(i_cos[2]);
    assign sw = $signed(i_sin[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cwcp <= mul_q30(cw, cp);
            r_swsp <= mul_q30(sw, sp);
            r_cwsp <= mul_q30(cw, sp);
            r_swcp <= mul_q30(sw, cp);
            r_cr   <= cr;
            r_sr   <= sr;
            r_qw <= mul_q30(r_cwcp, r_cr) + mul_q30(r_swsp, r_sr);
            r_qx <= mul_q30(r_cwcp, r_sr) - mul_q30(r_swsp, r_cr);
            r_qy <= mul_q30(r_cwsp, r_cr) + mul_q30(r_swcp, r_sr);
            r_qz <= mul_q30(r_swcp, r_cr) - mul_q30(r_cwsp, r_sr);
            r_xx <= mul_q30(r_qx, r_qx);
            r_yy <= mul_q30(r_qy, r_qy);
            r_zz <= mul_q30(r_qz, r_qz);
            r_xy <= mul_q30(r_qx, r_qy);
            r_xz <= mul_q30(r_qx, r_qz);
            r_yz <= mul_q30(r_qy, r_qz);
            r_wx <= mul_q30(r_qw, r_qx);
            r_wy <= mul_q30(r_qw, r_qy);
            r_wz <= mul_q30(r_qw, r_qz);
            r_m[0] <= 37'(ONE_Q30) - 37'((37'(r_yy) + 37'(r_zz)) <<< 1);
            r_m[1] <= (37'(r_xy) - 37'(r_wz)) <<< 1;
            r_m[2] <= (37'(r_xz) + 37'(r_wy)) <<< 1;
            r_m[3] <= (37'(r_xy) + 37'(r_wz)) <<< 1;
            r_m[4] <= 37'(ONE_Q30) - 37'((37'(r_xx) + 37'(r_zz)) <<< 1);
            r_m[5] <= (37'(r_yz) - 37'(r_wx)) <<< 1;
            r_m[6] <= (37'(r_xz) - 37'(r_wy)) <<< 1;
            r_m[7] <= (37'(r_yz) + 37'(r_wx)) <<< 1;
            r_m[8] <= 37'(ONE_Q30) - 37'((37'(r_xx) + 37'(r_yy)) <<< 1);
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) o_mat[k] = r_m[k];
    end
endmodule

// File: sv/eprp_apply.sv
// ----------------------------------------------------------------------------
// eprp_apply
// Matrix times offset, rounding, pivot add and saturation. Two stages.
// ----------------------------------------------------------------------------
module eprp_apply
    import eprp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [8:0][Q_WIDTH+2:0]       i_mat,
    input  logic [2:0][COORD_WIDTH:0]     i_d,
    input  logic [2:0][COORD_WIDTH-1:0]   i_c,
    output logic [2:0][COORD_WIDTH-1:0]   o_r,
    output logic                          o_sat
);
    localparam int PW = Q_WIDTH + 3 + COORD_WIDTH + 1;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] r_p [9];
    logic [2:0][COORD_WIDTH-1:0] r_c;
    logic signed [SW-1:0] acc [3];
    logic signed [SW-1:0] v [3];
    logic [2:0][COORD_WIDTH-1:0] n_r;
    logic n_sat;
    logic signed [SW-1:0] hi_b, lo_b;

    assign hi_b = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    assign lo_b = -(SW'(1) <<< (COORD_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++)
                r_p[k] <= PW'($signed(i_mat[k])) * PW'($signed(i_d[k%3]));
            r_c <= i_c;
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc[r] = SW'(r_p[3*r]) + SW'(r_p[3*r+1]) + SW'(r_p[3*r+2]) + SW'(HALF_Q30);
            v[r] = (acc[r] >>> 30) + SW'($signed(r_c[r]));
            if (v[r] > hi_b) begin
                n_r[r] = hi_b[COORD_WIDTH-1:0];
                n_sat = 1'b1;
            end else if (v[r] < lo_b) begin
                n_r[r] = lo_b[COORD_WIDTH-1:0];
                n_sat = 1'b1;
            end else begin
                n_r[r] = v[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r   <= n_r;
            o_sat <= n_sat;
        end
    end
endmodule

// File: sv/euler_point_rotation_about_pivot.sv
// ----------------------------------------------------------------------------
// euler_point_rotation_about_pivot
// Rotates a point about a pivot by roll, pitch and yaw angles.
// ----------------------------------------------------------------------------
// Input channel: point, pivot and three binary angles, i_valid/o_ready.
// Output channel: rotated point and saturation flag, o_valid/i_ready.
// One transaction per cycle sustained while the receiver accepts. The pipeline
// has one CORDIC micro-rotation stage per step (steps capped at 24), four
// quaternion/matrix stages, the offset path in parallel, one product stage
// and one output register.
// The whole pipeline advances together; when the receiver stalls with the
// output register full, every stage holds and o_ready drops, so nothing is
// lost or repeated. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module euler_point_rotation_about_pivot
    import eprp_pkg::*;
#(
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_WIDTH-1:0]  i_point_x,
    input  logic [COORD_WIDTH-1:0]  i_point_y,
    input  logic [COORD_WIDTH-1:0]  i_point_z,
    input  logic [COORD_WIDTH-1:0]  i_pivot_x,
    input  logic [COORD_WIDTH-1:0]  i_pivot_y,
    input  logic [COORD_WIDTH-1:0]  i_pivot_z,
    input  logic [ANGLE_WIDTH-1:0]  i_roll_angle,
    input  logic [ANGLE_WIDTH-1:0]  i_pitch_angle,
    input  logic [ANGLE_WIDTH-1:0]  i_yaw_angle,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [COORD_WIDTH-1:0]  o_rotated_x,
    output logic [COORD_WIDTH-1:0]  o_rotated_y,
    output logic [COORD_WIDTH-1:0]  o_rotated_z,
    output logic                    o_saturated
);
    localparam int NS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int LAT = NS + 6;

    logic en;
    logic [LAT-1:0] r_vld;
    logic [2:0][ANGLE_WIDTH-1:0] ang;
    logic [2:0][Q_WIDTH-1:0] cs, sn;
    logic [8:0][Q_WIDTH+2:0] mat;
    logic [2:0][COORD_WIDTH:0] r_d [NS+4];
    logic [2:0][COORD_WIDTH-1:0] r_cv [NS+4];
    logic [2:0][COORD_WIDTH-1:0] res;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];
    assign ang     = {i_yaw_angle, i_pitch_angle, i_roll_angle};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0][0] <= (COORD_WIDTH+1)'($signed(i_point_x)) - (COORD_WIDTH+1)'($signed(i_pivot_x));
            r_d[0][1] <= (COORD_WIDTH+1)'($signed(i_point_y)) - (COORD_WIDTH+1)'($signed(i_pivot_y));
            r_d[0][2] <= (COORD_WIDTH+1)'($signed(i_point_z)) - (COORD_WIDTH+1)'($signed(i_pivot_z));
            r_cv[0]   <= {i_pivot_z, i_pivot_y, i_pivot_x};
            for (int k = 1; k < NS + 4; k++) begin
                r_d[k]  <= r_d[k-1];
                r_cv[k] <= r_cv[k-1];
            end
        end
    end

    eprp_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_en(en), .i_angle(ang), .o_cos(cs), .o_sin(sn)
    );

    eprp_quat u_quat (
        .i_clk(i_clk), .i_en(en), .i_cos(cs), .i_sin(sn), .o_mat(mat)
    );

    eprp_apply #(.COORD_WIDTH(COORD_WIDTH)) u_apply (
        .i_clk(i_clk), .i_en(en), .i_mat(mat), .i_d(r_d[NS+3]), .i_c(r_cv[NS+3]),
        .o_r(res), .o_sat(o_saturated)
    );

    assign o_rotated_x = res[0];
    assign o_rotated_y = res[1];
    assign o_rotated_z = res[2];
endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the point rotation about a pivot. A directed table and then
// random transactions go in through valid/ready, with random gaps and
// receiver stalls. Each result is checked against a bit-exact model of the
// CORDIC, quaternion and matrix arithmetic, or against a fixed known result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int AW = 16;
    localparam int STEPS = 16;
    localparam int N_RANDOM = 1500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    localparam longint ATAN_TAB [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint GAIN = 652032874;
    localparam longint ONE = 64'sd1 << 30;
    localparam longint HALF = 64'sd1 << 29;

    typedef struct {
        logic [CW-1:0] px, py, pz, cx, cy, cz;
        logic [AW-1:0] roll, pitch, yaw;
    } point_txn_t;

    typedef struct {
        logic [CW-1:0] x, y, z;
        logic          sat;
    } rot_txn_t;

    typedef struct {
        point_txn_t in;
        bit         known;
        rot_txn_t   res;
    } dir_row_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [CW-1:0] i_point_x, i_point_y, i_point_z;
    logic [CW-1:0] i_pivot_x, i_pivot_y, i_pivot_z;
    logic [AW-1:0] i_roll_angle, i_pitch_angle, i_yaw_angle;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [CW-1:0] o_rotated_x, o_rotated_y, o_rotated_z;
    logic          o_saturated;

    euler_point_rotation_about_pivot i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_pivot_x(i_pivot_x), .i_pivot_y(i_pivot_y), .i_pivot_z(i_pivot_z),
        .i_roll_angle(i_roll_angle), .i_pitch_angle(i_pitch_angle),
        .i_yaw_angle(i_yaw_angle),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_rotated_x(o_rotated_x), .o_rotated_y(o_rotated_y),
        .o_rotated_z(o_rotated_z), .o_saturated(o_saturated)
    );

    rot_txn_t pending_rot[$];
    int       n_errors = 0;
    int       idle_cycles = 0;
    bit       no_idle;
    bit       stim_done;
    int       ready_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint rnd30(longint p);
        return (p + HALF) >>> 30;
    endfunction

    function automatic void half_sincos(logic [AW-1:0] a, output longint c,
                                        output longint s);
        longint z, x, y, xs, ys;
        z = longint'($signed(a)) * (64'sd1 <<< (31 - AW));
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint mul3(longint a, longint b, longint c);
        return rnd30(rnd30(a * b) * c);
    endfunction

    function automatic longint row_dot(longint m0, longint m1, longint m2,
                                       longint dx, longint dy, longint dz);
        logic signed [127:0] acc;
        acc = 128'(m0) * 128'(dx) + 128'(m1) * 128'(dy) + 128'(m2) * 128'(dz)
              + 128'(HALF);
        acc = acc >>> 30;
        return longint'(acc[63:0]);
    endfunction

    function automatic logic [CW-1:0] clip_coord(longint v, inout logic sat);
        longint hi, lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi) begin v = hi; sat = 1'b1; end
        if (v < lo) begin v = lo; sat = 1'b1; end
        return v[CW-1:0];
    endfunction

    function automatic rot_txn_t rotate_point(point_txn_t t);
        rot_txn_t r;
        longint cx, cy, cz, dx, dy, dz;
        longint cr, sr, cp, sp, cw, sw, qw, qx, qy, qz;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic sat;
        cx = $signed(t.cx); cy = $signed(t.cy); cz = $signed(t.cz);
        dx = longint'($signed(t.px)) - cx;
        dy = longint'($signed(t.py)) - cy;
        dz = longint'($signed(t.pz)) - cz;
        half_sincos(t.roll, cr, sr);
        half_sincos(t.pitch, cp, sp);
        half_sincos(t.yaw, cw, sw);
        qw = mul3(cw, cp, cr) + mul3(sw, sp, sr);
        qx = mul3(cw, cp, sr) - mul3(sw, sp, cr);
        qy = mul3(cw, sp, cr) + mul3(sw, cp, sr);
        qz = mul3(sw, cp, cr) - mul3(cw, sp, sr);
        xx = rnd30(qx * qx); yy = rnd30(qy * qy); zz = rnd30(qz * qz);
        xy = rnd30(qx * qy); xz = rnd30(qx * qz); yz = rnd30(qy * qz);
        wx = rnd30(qw * qx); wy = rnd30(qw * qy); wz = rnd30(qw * qz);
        sat = 1'b0;
        r.x = clip_coord(row_dot(ONE - 2 * (yy + zz), 2 * (xy - wz),
                                 2 * (xz + wy), dx, dy, dz) + cx, sat);
        r.y = clip_coord(row_dot(2 * (xy + wz), ONE - 2 * (xx + zz),
                                 2 * (yz - wx), dx, dy, dz) + cy, sat);
        r.z = clip_coord(row_dot(2 * (xz - wy), 2 * (yz + wx),
                                 ONE - 2 * (xx + yy), dx, dy, dz) + cz, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2, 3, 4: return CW'($signed($urandom_range(0, 32'h00FF_FFFF))
                                - 32'sh0080_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic point_txn_t rand_point();
        point_txn_t t;
        t.px = rand_coord(); t.py = rand_coord(); t.pz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
        t.roll = AW'($urandom()); t.pitch = AW'($urandom()); t.yaw = AW'($urandom());
        if ($urandom_range(0, 9) == 0) t.roll = {1'b1, {(AW-1){1'b0}}};
        if ($urandom_range(0, 9) == 0) t.yaw = {1'b0, {(AW-1){1'b1}}};
        return t;
    endfunction

    task automatic send_point(point_txn_t t, rot_txn_t exp_rot);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= t.px; i_point_y <= t.py; i_point_z <= t.pz;
        i_pivot_x     <= t.cx; i_pivot_y <= t.cy; i_pivot_z <= t.cz;
        i_roll_angle  <= t.roll; i_pitch_angle <= t.pitch;
        i_yaw_angle   <= t.yaw;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        pending_rot.push_back(exp_rot);
    endtask

    // receiver: check accepted results, randomize i_ready
    always @(posedge i_clk) begin
        rot_txn_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rot.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h sat=%b", $time,
                         o_rotated_x, o_rotated_y, o_rotated_z, o_saturated);
                n_errors++;
            end else begin
                e = pending_rot.pop_front();
                if (o_rotated_x !== e.x) begin
                    $display("%0t: x exp %h got %h", $time, e.x, o_rotated_x);
                    n_errors++;
                end
                if (o_rotated_y !== e.y) begin
                    $display("%0t: y exp %h got %h", $time, e.y, o_rotated_y);
                    n_errors++;
                end
                if (o_rotated_z !== e.z) begin
                    $display("%0t: z exp %h got %h", $time, e.z, o_rotated_z);
                    n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: sat exp %b got %b", $time, e.sat, o_saturated);
                    n_errors++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            ready_hold <= gap_len();
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // watchdog on transactions
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n
            || (stim_done && pending_rot.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        dir_row_t   dir_tab[$];
        dir_row_t   row;
        point_txn_t t;
        rot_txn_t   r;
        logic [CW-1:0] cmax, cmin;
        logic [AW-1:0] amax, amin;
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        amax = {1'b0, {(AW-1){1'b1}}};
        amin = {1'b1, {(AW-1){1'b0}}};
        no_idle = 0; stim_done = 0;
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_pivot_x = '0; i_pivot_y = '0; i_pivot_z = '0;
        i_roll_angle = '0; i_pitch_angle = '0; i_yaw_angle = '0;

        // point on the pivot: result is the pivot itself, any angles
        row.known = 1;
        row.in = '{'0, '0, '0, '0, '0, '0, '0, '0, '0};
        row.res = '{'0, '0, '0, 1'b0};
        dir_tab.push_back(row);
        row.in = '{cmax, cmin, cmax, cmax, cmin, cmax, amin, amin, amin};
        row.res = '{cmax, cmin, cmax, 1'b0};
        dir_tab.push_back(row);
        row.in = '{cmin, cmax, cmin, cmin, cmax, cmin, amax, amax, amax};
        row.res = '{cmin, cmax, cmin, 1'b0};
        dir_tab.push_back(row);
        row.known = 0;
        row.in = '{cmax, cmax, cmax, '0, '0, '0, '0, '0, '0};
        dir_tab.push_back(row);
        row.in = '{cmin, cmin, cmin, '0, '0, '0, '0, '0, '0};
        dir_tab.push_back(row);
        row.in = '{32'h0001_0000, '0, '0, '0, '0, '0, amin, '0, '0};
        dir_tab.push_back(row);
        row.in = '{32'h0001_0000, '0, '0, '0, '0, '0, '0, amin, '0};
        dir_tab.push_back(row);
        row.in = '{32'h0001_0000, '0, '0, '0, '0, '0, '0, '0, amin};
        dir_tab.push_back(row);
        row.in = '{'0, 32'h0001_0000, '0, '0, '0, '0, amax, '0, '0};
        dir_tab.push_back(row);
        row.in = '{'0, '0, 32'h0001_0000, '0, '0, '0, '0, amax, amax};
        dir_tab.push_back(row);
        row.in = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0,
                   16'h4000, 16'h2000, 16'hC000};
        dir_tab.push_back(row);
        // saturation: far offsets spun by half turns; last, a full-scale offset under tiny angles
        row.in = '{cmax, cmax, cmax, cmin, cmin, cmin, '0, '0, amin};
        dir_tab.push_back(row);
        row.in = '{cmin, cmin, cmin, cmax, cmax, cmax, amin, '0, '0};
        dir_tab.push_back(row);
        row.in = '{cmax, cmin, cmax, cmin, cmax, cmin, amax, amax, amin};
        dir_tab.push_back(row);
        row.in = '{cmax, '0, '0, '0, '0, '0, 16'h0001, 16'hFFFF, 16'h0001};
        dir_tab.push_back(row);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            r = dir_tab[k].known ? dir_tab[k].res : rotate_point(dir_tab[k].in);
            send_point(dir_tab[k].in, r);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 300 == 0) no_idle = (n == 600);
            t = rand_point();
            send_point(t, rotate_point(t));
        end
        i_valid <= 1'b0;
        stim_done = 1;
        no_idle = 1;
        while (pending_rot.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_rot.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
